// ===== src/linear_probe_hash_table_macros.svh =====
// ---------------------------------------------------------------------------
// linear_probe_hash_table_macros.svh
// Assertion macros for the hash table block; empty bodies under synthesis.
// ---------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while in reset.
`define LPHT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpht assertion failed");

// Next-cycle implication, disabled while in reset.
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpht assertion failed");

`else

`define LPHT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/lpht_pkg.sv =====
// ---------------------------------------------------------------------------
// lpht_pkg
// Shared widths, codes and types for the linear probing hash table.
// ---------------------------------------------------------------------------
package lpht_pkg;

    localparam int CAPACITY   = 1024;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    localparam int MODE_W     = 2;
    localparam int KEY_W      = 31;
    localparam int VAL_W      = 32;
    localparam int SIZE_W     = 11;
    localparam int STAT_W     = 2;
    localparam int OCC_W      = 11;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

    // key % size unit: dividend padded to MOD_PAD_W, MOD_DIGIT bits per cycle
    localparam int MOD_PAD_W  = 32;
    localparam int MOD_DIGIT  = 4;
    localparam int MOD_STEPS  = MOD_PAD_W / MOD_DIGIT;
    localparam int MOD_STEP_W = $clog2(MOD_STEPS);

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } slot_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        slot_t            wr_data;
    } ram_cmd_t;

endpackage

// ===== src/lpht_ifs.sv =====
// ---------------------------------------------------------------------------
// lpht_ifs
// Handshake channels: request in, response out, size register write.
// ---------------------------------------------------------------------------
interface lpht_req_if import lpht_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [MODE_W-1:0]       mode;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, mode, key, value, input ready);
    modport sink (input valid, mode, key, value, output ready);
endinterface

interface lpht_rsp_if import lpht_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] found_value;
    logic [OCC_W-1:0]        occupancy;

    modport source (output valid, status, found_value, occupancy, input ready);
    modport sink (input valid, status, found_value, occupancy, output ready);
endinterface

interface lpht_cfg_if import lpht_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== src/lpht_mod.sv =====
// ---------------------------------------------------------------------------
// lpht_mod
// Iterative key modulo size: restoring remainder, MOD_DIGIT bits per cycle.
// ---------------------------------------------------------------------------
module lpht_mod import lpht_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [KEY_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [IDX_W-1:0] rem
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [MOD_STEP_W-1:0] step_reg;
    logic [MOD_PAD_W-1:0]  shift_reg;
    logic [CNT_W-1:0]      rem_reg;
    logic [CNT_W-1:0]      div_reg;
    logic [CNT_W-1:0]      rem_next;

    // MOD_DIGIT shift-compare-subtract steps; remainder stays below divisor
    always_comb
    begin
        logic [CNT_W:0] trial;
        rem_next = rem_reg;
        for (int i = 0; i < MOD_DIGIT; i++)
        begin
            trial = {rem_next, shift_reg[MOD_PAD_W-1-i]};
            if (trial >= {1'b0, div_reg})
                trial = trial - {1'b0, div_reg};
            rem_next = trial[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == MOD_STEP_W'(MOD_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= MOD_PAD_W'(dividend);
            rem_reg   <= '0;
            div_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            shift_reg <= shift_reg << MOD_DIGIT;
            rem_reg   <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg[IDX_W-1:0];

endmodule

// ===== src/lpht_slot_store.sv =====
// ---------------------------------------------------------------------------
// lpht_slot_store
// Slot memory: one write and one registered read port.
// ---------------------------------------------------------------------------
module lpht_slot_store import lpht_pkg::*; (
    input  logic     clk,
    input  ram_cmd_t cmd,
    output slot_t    rd_data
);

    slot_t mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[cmd.wr_addr] <= cmd.wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
            rd_data <= mem[cmd.rd_addr];
    end

endmodule

// ===== src/linear_probe_hash_table.sv =====
// ---------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressed key/value table with linear probing over one slot memory.
// ---------------------------------------------------------------------------
//  channel  dir  payload                              moves per request
//  req      in   mode, key, value                     one operation
//  rsp      out  status, found_value, occupancy       one result
//  cfg      in   data (table_size)                    one register write
//
//  Probing: the key-mod-size unit first computes the home slot; the probe
//    loop then reads one slot per cycle from the single read port of the
//    slot memory, p = slots probed per request (1..size in use).
//  Reset: a clearing pass writes all CAPACITY (1024) slots empty;
//    req.ready stays low until it ends, cfg writes are taken throughout.
//  Stalls: a finished result waits in the rsp register, and the next request
//    is taken meanwhile; only a second finished result waits for rsp.ready.
// ---------------------------------------------------------------------------
`include "linear_probe_hash_table_macros.svh"

module linear_probe_hash_table import lpht_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    lpht_cfg_if.sink   cfg,
    lpht_req_if.sink   req,
    lpht_rsp_if.source rsp
);

    // control states
    localparam logic [2:0] S_CLEAR = 3'd0;  // reset sweep of the slot memory
    localparam logic [2:0] S_IDLE  = 3'd1;  // waiting for a request
    localparam logic [2:0] S_MOD   = 3'd2;  // home slot being computed
    localparam logic [2:0] S_CHK   = 3'd3;  // one slot checked per cycle
    localparam logic [2:0] S_DONE  = 3'd4;  // result handed to rsp register

    logic [2:0]              state_reg, state_next;
    logic [IDX_W-1:0]        clr_idx_reg, clr_idx_next;
    logic [SIZE_W-1:0]       size_reg;
    logic [MODE_W-1:0]       mode_reg, mode_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [VAL_W-1:0]        value_reg, value_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [STAT_W-1:0]       res_status_reg, res_status_next;
    logic [VAL_W-1:0]        res_found_reg, res_found_next;
    logic                    out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]       out_status_reg, out_status_next;
    logic [VAL_W-1:0]        out_found_reg, out_found_next;
    logic [OCC_W-1:0]        out_occ_reg, out_occ_next;

    logic [CNT_W-1:0]        size_use;
    logic                    mod_start;
    logic                    mod_done;
    logic [IDX_W-1:0]        mod_rem;
    ram_cmd_t                ram_cmd;
    slot_t                   slot_rd;

    // size in use: zero acts as one, anything above CAPACITY as CAPACITY
    always_comb
    begin
        if (size_reg == '0)
            size_use = CNT_W'(1);
        else if (int'(size_reg) > CAPACITY)
            size_use = CNT_W'(CAPACITY);
        else
            size_use = CNT_W'(size_reg);
    end

    lpht_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (req.key),
        .divisor  (size_use),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    lpht_slot_store u_store (
        .clk     (clk),
        .cmd     (ram_cmd),
        .rd_data (slot_rd)
    );

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.found_value = out_found_reg;
    assign rsp.occupancy   = out_occ_reg;

    always_comb
    begin
        logic             last_probe;
        logic             key_hit;
        logic [IDX_W-1:0] pos_inc;

        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        pos_next        = pos_reg;
        n_next          = n_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_occ_next    = out_occ_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        mod_start       = 1'b0;
        ram_cmd         = '0;

        // probe bookkeeping for the slot now on the read port
        last_probe = ((n_reg + 1'b1) == size_use);
        key_hit    = slot_rd.valid && (slot_rd.key == key_reg);
        if ((CNT_W'(pos_reg) + 1'b1) == size_use)
            pos_inc = '0;
        else
            pos_inc = pos_reg + 1'b1;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_cmd.wr_en   = 1'b1;
                ram_cmd.wr_addr = clr_idx_reg;
                ram_cmd.wr_data = '0;
                clr_idx_next    = clr_idx_reg + 1'b1;
                if (clr_idx_reg == IDX_W'(CAPACITY - 1))
                    state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next  = req.mode;
                    key_next   = req.key;
                    value_next = req.value;
                    mod_start  = 1'b1;
                    state_next = S_MOD;
                end
            end

            S_MOD:
            begin
                if (mod_done)
                begin
                    pos_next        = mod_rem;
                    n_next          = '0;
                    ram_cmd.rd_en   = 1'b1;
                    ram_cmd.rd_addr = mod_rem;
                    state_next      = S_CHK;
                end
            end

            S_CHK:
            begin
                // default outcome: keep probing at the next slot
                res_found_next = '1;
                n_next         = n_reg + 1'b1;
                pos_next       = pos_inc;
                case (mode_reg) inside
                    MODE_INSERT:
                    begin
                        if (!slot_rd.valid)
                        begin
                            ram_cmd.wr_en         = 1'b1;
                            ram_cmd.wr_addr       = pos_reg;
                            ram_cmd.wr_data.valid = 1'b1;
                            ram_cmd.wr_data.key   = key_reg;
                            ram_cmd.wr_data.value = value_reg;
                            count_next            = count_reg + 1'b1;
                            res_status_next       = ST_OK;
                            state_next            = S_DONE;
                        end
                        else if (last_probe)
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            ram_cmd.rd_en   = 1'b1;
                            ram_cmd.rd_addr = pos_inc;
                        end
                    end

                    MODE_SEARCH, MODE_DELETE:
                    begin
                        if (key_hit)
                        begin
                            res_status_next = ST_OK;
                            state_next      = S_DONE;
                            if (mode_reg == MODE_SEARCH)
                                res_found_next = slot_rd.value;
                            else
                            begin
                                // no tombstone: the slot simply goes empty
                                ram_cmd.wr_en         = 1'b1;
                                ram_cmd.wr_addr       = pos_reg;
                                ram_cmd.wr_data.valid = 1'b0;
                                ram_cmd.wr_data.key   = '0;
                                ram_cmd.wr_data.value = '1;
                                if (count_reg != '0)
                                    count_next = count_reg - 1'b1;
                            end
                        end
                        else if (!slot_rd.valid || last_probe)
                        begin
                            res_status_next = ST_MISS;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            ram_cmd.rd_en   = 1'b1;
                            ram_cmd.rd_addr = pos_inc;
                        end
                    end

                    default:
                    begin
                        // undefined mode: no change, reported as a miss
                        res_status_next = ST_MISS;
                        state_next      = S_DONE;
                    end
                endcase
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_found_next  = res_found_reg;
                    out_occ_next    = OCC_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            size_reg      <= SIZE_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
                size_reg <= cfg.data;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        key_reg        <= key_next;
        value_reg      <= value_next;
        pos_reg        <= pos_next;
        n_reg          <= n_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_occ_reg    <= out_occ_next;
    end

    // occupancy can never pass the slot count
    `LPHT_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, int'(count_reg) <= CAPACITY)

    // the probe loop never runs past the size in use
    `LPHT_ASSERT_NOW(a_probe_bound, clk, rst_n, state_reg == S_CHK, n_reg < size_use)

    // slot memory is written only by the sweep or by a resolving probe
    `LPHT_ASSERT_NEXT(a_write_ends, clk, rst_n, ram_cmd.wr_en && state_reg == S_CHK, state_reg == S_DONE)

    // a result is only loaded into the rsp register from the done state
    `LPHT_ASSERT_NOW(a_out_load, clk, rst_n, !out_valid_reg && out_valid_next, state_reg == S_DONE)

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Checks the linear probing hash table: a directed script, then random
// insert/search/delete and bad-mode traffic across several table sizes, with
// each response compared against a software copy of the slot store or, for typed rows, a hand-written one.
// ---------------------------------------------------------------------------
module tb_top;
    import lpht_pkg::*;

    // Mode 3 is not an operation; the block must answer "not found" and
    // leave the table alone.
    localparam logic [MODE_W-1:0] MODE_UNDEF = 2'd3;

    // Watchdog limit, kept well above the worst correct run, in which every request
    // is a full 1024-slot scan under the longest gaps on both sides.
    localparam int LIMIT_CYCLES = 2000000;
    // Longest single request: a full scan of 1024 slots plus the modulo unit.
    localparam int TAIL_CYCLES  = 1100;
    localparam int PHASE_ITEMS  = 40;
    localparam int POOL_DEPTH   = 48;

    // One response as the block should produce it.
    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic signed [VAL_W-1:0] found;
        logic [OCC_W-1:0]        occ;
    } outcome_t;

    // One row of the directed script: either a size write or a request.
    // Rows marked typed carry their response written out by hand.
    typedef struct packed {
        bit                is_size;
        logic [SIZE_W-1:0] size;
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  val;
        bit                typed;
        outcome_t          want;
    } step_t;

    logic clk;
    logic rst_n;

    lpht_cfg_if cfg ();
    lpht_req_if req ();
    lpht_rsp_if rsp ();

    linear_probe_hash_table u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

    // -----------------------------------------------------------------------
    // Shadow of the slot store and size register
    // -----------------------------------------------------------------------
    logic              slot_used [CAPACITY];
    logic [KEY_W-1:0]  slot_key  [CAPACITY];
    logic [VAL_W-1:0]  slot_val  [CAPACITY];
    int unsigned       used_cnt;
    logic [SIZE_W-1:0] size_reg;

    outcome_t          pending_q [$];      // responses still owed, oldest first
    logic [KEY_W-1:0]  key_pool  [$];      // recently inserted keys, for hits
    step_t             script    [$];

    int unsigned fail_cnt;
    int unsigned mode_tally   [4];
    int unsigned status_tally [3];
    int unsigned cycle_cnt;
    int unsigned rsp_hold_cycles;          // set by stimulus, drained by receiver
    bit          sender_steady;            // no request gaps in this phase
    int unsigned span_plan [10] = '{3, 1, 16, 2, 64, 1024, 7, 200, 5, 1024};

    // -----------------------------------------------------------------------
    // Clock, reset, watchdog
    // -----------------------------------------------------------------------
    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("tb_top failed");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Predictor
    // -----------------------------------------------------------------------
    // Effective size: 0 behaves as 1, anything past capacity as capacity.
    function automatic int unsigned span_now();
        if (size_reg == 0)
            return 1;
        if (size_reg > CAPACITY)
            return CAPACITY;
        return size_reg;
    endfunction

    // Walk the probe path from the home slot; an empty slot ends the chain.
    function automatic bit find_slot(input logic [KEY_W-1:0] k, input int unsigned span,
                                     output int unsigned idx);
        int unsigned pos;
        int unsigned n;
        pos = k % span;
        for (n = 0; n < span; n++)
        begin
            if (!slot_used[pos])
                return 1'b0;
            if (slot_key[pos] == k)
            begin
                idx = pos;
                return 1'b1;
            end
            pos = (pos + 1 == span) ? 0 : pos + 1;
        end
        return 1'b0;
    endfunction

    function automatic outcome_t hash_table_step(input logic [MODE_W-1:0] m,
                                                 input logic [KEY_W-1:0] k,
                                                 input logic [VAL_W-1:0] v);
        outcome_t    res;
        int unsigned span;
        int unsigned pos;
        int unsigned n;
        int unsigned hit;
        bit          placed;
        span       = span_now();
        res.status = ST_MISS;
        res.found  = '1;
        if (m == MODE_INSERT)
        begin
            // no duplicate check: first empty slot wins
            res.status = ST_FULL;
            pos        = k % span;
            placed     = 1'b0;
            for (n = 0; n < span && !placed; n++)
            begin
                if (!slot_used[pos])
                begin
                    slot_used[pos] = 1'b1;
                    slot_key[pos]  = k;
                    slot_val[pos]  = v;
                    used_cnt++;
                    res.status     = ST_OK;
                    placed         = 1'b1;
                end
                pos = (pos + 1 == span) ? 0 : pos + 1;
            end
        end
        else if (m == MODE_SEARCH)
        begin
            if (find_slot(k, span, hit))
            begin
                res.status = ST_OK;
                res.found  = slot_val[hit];
            end
        end
        else if (m == MODE_DELETE)
        begin
            // no tombstone, so later chains through this slot get cut
            if (find_slot(k, span, hit))
            begin
                slot_used[hit] = 1'b0;
                slot_key[hit]  = '0;
                slot_val[hit]  = '1;
                if (used_cnt > 0)
                    used_cnt--;
                res.status = ST_OK;
            end
        end
        res.occ = OCC_W'(used_cnt);
        return res;
    endfunction

    // -----------------------------------------------------------------------
    // Script row builders
    // -----------------------------------------------------------------------
    function automatic step_t size_row(input logic [SIZE_W-1:0] s);
        step_t r;
        r         = '0;
        r.is_size = 1'b1;
        r.size    = s;
        return r;
    endfunction

    function automatic step_t req_row(input logic [MODE_W-1:0] m, input logic [KEY_W-1:0] k,
                                      input logic [VAL_W-1:0] v);
        step_t r;
        r      = '0;
        r.mode = m;
        r.key  = k;
        r.val  = v;
        return r;
    endfunction

    function automatic step_t typed_row(input logic [MODE_W-1:0] m, input logic [KEY_W-1:0] k,
                                        input logic [VAL_W-1:0] v, input logic [STAT_W-1:0] st,
                                        input logic [VAL_W-1:0] fv, input logic [OCC_W-1:0] oc);
        step_t r;
        r             = req_row(m, k, v);
        r.typed       = 1'b1;
        r.want.status = st;
        r.want.found  = fv;
        r.want.occ    = oc;
        return r;
    endfunction

    // Mostly zero, some short, a few long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key(input int unsigned span);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50 && key_pool.size() != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        if (r < 85)
            return KEY_W'($urandom_range(0, 4 * span));
        return KEY_W'($urandom());
    endfunction

    // -----------------------------------------------------------------------
    // Request and size-write drivers
    // -----------------------------------------------------------------------
    task automatic issue_request(input logic [MODE_W-1:0] m, input logic [KEY_W-1:0] k,
                                 input logic [VAL_W-1:0] v, input bit typed,
                                 input outcome_t want);
        int unsigned gap;
        outcome_t    calc;
        gap = sender_steady ? 0 : pick_gap();
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.mode  <= m;
        req.key   <= k;
        req.value <= v;
        do
            @(posedge clk);
        while (!req.ready);
        // request taken at this edge: advance the shadow and queue its response
        calc = hash_table_step(m, k, v);
        if (typed)
            calc = want;
        pending_q.push_back(calc);
        mode_tally[m]++;
        if (calc.status <= ST_FULL)
            status_tally[calc.status]++;
        if (m == MODE_INSERT)
        begin
            key_pool.push_back(k);
            if (key_pool.size() > POOL_DEPTH)
                void'(key_pool.pop_front());
        end
    endtask

    // Stop offering requests and let every owed response come back.
    task automatic wait_drained();
        req.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_q.size() != 0);
    endtask

    // Only called with no request in flight (the first time during the clearing pass).
    task automatic write_size(input logic [SIZE_W-1:0] s);
        cfg.valid <= 1'b1;
        cfg.data  <= s;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        size_reg = s;
    endtask

    // -----------------------------------------------------------------------
    // Response side: check each accepted response, then pick next ready
    // -----------------------------------------------------------------------
    task automatic check_response();
        outcome_t want;
        if (pending_q.size() == 0)
        begin
            $error("unexpected response: status %0d found %h occupancy %0d",
                   rsp.status, rsp.found_value, rsp.occupancy);
            fail_cnt++;
            return;
        end
        want = pending_q.pop_front();
        if (rsp.status !== want.status)
        begin
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
            fail_cnt++;
        end
        if (rsp.found_value !== want.found)
        begin
            $error("found_value: expected %h, actual %h", want.found, rsp.found_value);
            fail_cnt++;
        end
        if (rsp.occupancy !== want.occ)
        begin
            $error("occupancy: expected %0d, actual %0d", want.occ, rsp.occupancy);
            fail_cnt++;
        end
    endtask

    initial
    begin
        int unsigned stall_left;
        int unsigned seg_left;
        bit          calm;
        rsp.ready  = 1'b0;
        stall_left = 0;
        seg_left   = 0;
        calm       = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp.valid && rsp.ready)
                check_response();
            if (rsp_hold_cycles != 0)
            begin
                // long hold-off: the block must back up and stall requests
                rsp_hold_cycles--;
                rsp.ready <= 1'b0;
            end
            else
            begin
                // alternate stretches of always-ready with stretches of stalls
                if (seg_left == 0)
                begin
                    calm     = ($urandom_range(0, 2) == 0);
                    seg_left = $urandom_range(20, 120);
                end
                seg_left--;
                if (stall_left != 0)
                begin
                    stall_left--;
                    rsp.ready <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 3) == 0)
                begin
                    stall_left = pick_gap();
                    rsp.ready <= 1'b0;
                end
                else
                    rsp.ready <= 1'b1;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial
    begin
        int unsigned      p;
        int unsigned      i;
        int unsigned      r;
        int unsigned      span;
        logic [MODE_W-1:0] m;
        // every input known from time zero
        rst_n     = 1'b0;
        req.valid = 1'b0;
        req.mode  = MODE_INSERT;
        req.key   = '0;
        req.value = '0;
        cfg.valid = 1'b0;
        cfg.data  = '0;
        fail_cnt  = 0;
        used_cnt  = 0;
        size_reg  = SIZE_RESET;
        rsp_hold_cycles = 0;
        sender_steady   = 1'b0;
        for (i = 0; i < CAPACITY; i++)
        begin
            slot_used[i] = 1'b0;
            slot_key[i]  = '0;
            slot_val[i]  = '0;
        end
        for (i = 0; i < 4; i++)
            mode_tally[i] = 0;
        for (i = 0; i < 3; i++)
            status_tally[i] = 0;

        // Directed script. Slot numbers in the notes are for the size in force.
        script = '{
            size_row(11'd1024),                                  // during clearing pass
            typed_row(MODE_SEARCH, 31'd5, 32'd0, ST_MISS, '1, 11'd0),
            typed_row(MODE_DELETE, 31'd5, 32'd0, ST_MISS, '1, 11'd0),
            typed_row(MODE_UNDEF, 31'h7FFF_FFFF, 32'h1234_5678, ST_MISS, '1, 11'd0),
            typed_row(MODE_INSERT, 31'h7FFF_FFFF, 32'h7FFF_FFFF, ST_OK, '1, 11'd1), // slot 1023
            typed_row(MODE_SEARCH, 31'h7FFF_FFFF, 32'd0, ST_OK, 32'h7FFF_FFFF, 11'd1),
            typed_row(MODE_INSERT, 31'd0, 32'h8000_0000, ST_OK, '1, 11'd2),        // slot 0
            typed_row(MODE_SEARCH, 31'd0, 32'hFFFF_FFFF, ST_OK, 32'h8000_0000, 11'd2),
            size_row(11'd0),                                     // zero acts as one slot
            typed_row(MODE_INSERT, 31'd3, 32'd1, ST_FULL, '1, 11'd2),
            typed_row(MODE_SEARCH, 31'd0, 32'd0, ST_OK, 32'h8000_0000, 11'd2),
            // slot 1023 still counts but is out of reach
            typed_row(MODE_SEARCH, 31'h7FFF_FFFF, 32'd0, ST_MISS, '1, 11'd2),
            size_row(11'd2047),                                  // clamps to capacity
            req_row(MODE_INSERT, 31'd1024, 32'd7),               // collides, goes to slot 1
            req_row(MODE_SEARCH, 31'd1024, 32'd0),
            size_row(11'd4),
            req_row(MODE_INSERT, 31'd4, 32'd44),                 // probes to slot 2
            req_row(MODE_INSERT, 31'd7, 32'd77),                 // slot 3
            req_row(MODE_INSERT, 31'd8, 32'd88),                 // no room left
            req_row(MODE_SEARCH, 31'd8, 32'd0),                  // full wrap, miss
            req_row(MODE_DELETE, 31'd1024, 32'd0),               // empties slot 1
            req_row(MODE_SEARCH, 31'd4, 32'd0),                  // chain cut by the delete
            req_row(MODE_INSERT, 31'd4, 32'd45),                 // duplicate lands in slot 1
            req_row(MODE_SEARCH, 31'd4, 32'd0),
            req_row(MODE_DELETE, 31'd0, 32'd0),
            req_row(MODE_SEARCH, 31'd7, 32'd0),
            req_row(MODE_INSERT, 31'd3, 32'd33),                 // wraps from slot 3 to 0
            size_row(11'd1024),
            req_row(MODE_DELETE, 31'h7FFF_FFFF, 32'd0)
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[s])
        begin
            if (script[s].is_size)
            begin
                wait_drained();
                write_size(script[s].size);
            end
            else
                issue_request(script[s].mode, script[s].key, script[s].val,
                              script[s].typed, script[s].want);
        end

        // Random phases, one table size each
        for (p = 0; p < 10; p++)
        begin
            wait_drained();
            write_size(SIZE_W'(span_plan[p]));
            span          = span_now();
            sender_steady = (p % 3 == 1);
            if (p == 2)
                rsp_hold_cycles = 300;   // sender keeps pushing through this
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 4 && i == PHASE_ITEMS / 2)
                    wait_drained();      // sender pause until all responses are in
                r = $urandom_range(0, 99);
                if (r < 45)
                    m = MODE_INSERT;
                else if (r < 75)
                    m = MODE_SEARCH;
                else if (r < 95)
                    m = MODE_DELETE;
                else
                    m = MODE_UNDEF;
                issue_request(m, pick_key(span), VAL_W'($urandom()), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d requests: %0d insert, %0d search, %0d delete, %0d bad mode",
                 mode_tally[0] + mode_tally[1] + mode_tally[2] + mode_tally[3],
                 mode_tally[MODE_INSERT], mode_tally[MODE_SEARCH],
                 mode_tally[MODE_DELETE], mode_tally[MODE_UNDEF]);
        $display("Outcomes: %0d done/found, %0d not found, %0d full; %0d mismatches",
                 status_tally[ST_OK], status_tally[ST_MISS], status_tally[ST_FULL], fail_cnt);
        if (fail_cnt == 0 && pending_q.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/lpht_pkg.sv
src/lpht_ifs.sv
src/lpht_mod.sv
src/lpht_slot_store.sv
src/linear_probe_hash_table.sv
tb/tb_top.sv
